[rtl/jsc_pkg.sv]
package jsc_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [CFG_IDX_BITS-1:0] REG_TOP_FORM    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FIELDS  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ITEMS   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RECORDS = 2'd3;

    localparam logic [4:0] S_TOP       = 5'd0;
    localparam logic [4:0] S_REC_FIRST = 5'd1;
    localparam logic [4:0] S_REC_NEXT  = 5'd2;
    localparam logic [4:0] S_REC_AFTER = 5'd3;
    localparam logic [4:0] S_END       = 5'd4;
    localparam logic [4:0] S_OBJ_FIRST = 5'd5;
    localparam logic [4:0] S_OBJ_KEY   = 5'd6;
    localparam logic [4:0] S_COLON     = 5'd7;
    localparam logic [4:0] S_VALUE     = 5'd8;
    localparam logic [4:0] S_ARR_FIRST = 5'd9;
    localparam logic [4:0] S_AFTER     = 5'd10;
    localparam logic [4:0] S_STR       = 5'd11;
    localparam logic [4:0] S_STR_ESC   = 5'd12;
    localparam logic [4:0] S_STR_HEX   = 5'd13;
    localparam logic [4:0] S_NUM_SIGN  = 5'd14;
    localparam logic [4:0] S_NUM_ZERO  = 5'd15;
    localparam logic [4:0] S_NUM_INT   = 5'd16;
    localparam logic [4:0] S_NUM_DOT   = 5'd17;
    localparam logic [4:0] S_NUM_FRAC  = 5'd18;
    localparam logic [4:0] S_NUM_EXP   = 5'd19;
    localparam logic [4:0] S_NUM_ESIGN = 5'd20;
    localparam logic [4:0] S_NUM_EDIG  = 5'd21;
    localparam logic [4:0] S_LIT_T     = 5'd22;
    localparam logic [4:0] S_LIT_F     = 5'd23;
    localparam logic [4:0] S_LIT_N     = 5'd24;

    // byte classes worked out by the front end
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ws;
        logic       digit;
        logic       hex;
        logic       expo;
        logic       ctrl;
        logic       esc;
    } cls_byte_t;

    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            2'd0: case (p)
                3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
                default: c = 8'h00;
            endcase
            2'd1: case (p)
                3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
                3'd4: c = "e";
                default: c = 8'h00;
            endcase
            2'd2: case (p)
                3'd0: c = "n"; 3'd1: c = "u"; 3'd2: c = "l"; 3'd3: c = "l";
                default: c = 8'h00;
            endcase
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/jsc_if.sv]
interface jsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface jsc_out_if;
    logic valid;
    logic ready;
    logic verdict;
    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

[rtl/jsc_front.sv]
module jsc_front (
    jsc_in_if.sink              in_ch,
    output logic                push,
    output jsc_pkg::cls_byte_t  push_data,
    input  logic                q_full
);
    import jsc_pkg::*;

    logic [7:0] c;

    assign c = in_ch.data_byte;
    assign in_ch.ready = !q_full;
    assign push = in_ch.valid && !q_full;

    always_comb
    begin
        push_data.data  = c;
        push_data.last  = in_ch.last;
        push_data.ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
        push_data.digit = (c >= "0") && (c <= "9");
        push_data.hex   = push_data.digit || ((c >= "a") && (c <= "f"))
                          || ((c >= "A") && (c <= "F"));
        push_data.expo  = (c == "e") || (c == "E");
        push_data.ctrl  = c < 8'h20;
        push_data.esc   = (c == "\"") || (c == "\\") || (c == "/") || (c == "b")
                          || (c == "f") || (c == "n") || (c == "r") || (c == "t");
    end
endmodule

[rtl/jsc_fifo.sv]
module jsc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jsc_pkg::cls_byte_t  push_data,
    output logic                full,
    input  logic                pop,
    output jsc_pkg::cls_byte_t  pop_data,
    output logic                not_empty
);
    import jsc_pkg::*;

    cls_byte_t  mem_reg [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_data = mem_reg[rd_reg];

    always_comb
    begin
        wr_next = wr_reg ^ push;
        rd_next = rd_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end
endmodule

[rtl/jsc_back.sv]
module jsc_back #(
    parameter int MAX_DEPTH = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  jsc_pkg::cls_byte_t  q_data,
    output logic                q_pop,
    input  logic                top_form,
    input  logic [9:0]          max_fields,
    input  logic [9:0]          max_items,
    input  logic [9:0]          max_records,
    jsc_out_if.source           out_ch
);
    import jsc_pkg::*;

    localparam int STACK_SIZE = MAX_DEPTH + 2;
    localparam int LVL_BITS = $clog2(STACK_SIZE + 1);
    localparam int IDX_BITS = $clog2(STACK_SIZE);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [4:0]            st_reg, st_next;
    logic [LVL_BITS-1:0]   lvl_reg, lvl_next;
    logic [COUNT_BITS-1:0] rec_reg, rec_next;
    logic [3:0]            tp_reg, tp_next;
    logic                  err_reg, err_next;
    logic                  arr_flag_reg [STACK_SIZE];
    logic [COUNT_BITS-1:0] cnt_reg [STACK_SIZE];
    logic                  ov_reg, ov_next;
    logic                  vd_reg, vd_next;

    logic                  go;
    logic                  bump_en, push_en, push_arr, pop_en;
    logic [IDX_BITS-1:0]   top_idx;
    logic                  top_arr;
    logic [COUNT_BITS-1:0] top_cnt;
    logic [COUNT_BITS-1:0] lim;
    logic                  bump_ok;
    logic [7:0]            c;
    logic [4:0]            s;
    logic                  num_done;
    logic [1:0]            lw;
    logic [2:0]            llen;
    logic [4:0]            st_fin;
    logic                  err_fin;

    function automatic logic [COUNT_BITS-1:0] capv(input logic [9:0] v);
        logic [16:0] w;
        w = 17'(v);
        return (w < 17'(CNT_MAX)) ? COUNT_BITS'(w) : CNT_MAX;
    endfunction

    // only a last byte has to wait for the verdict register
    assign go = q_valid && (!q_data.last || !ov_reg || out_ch.ready);
    assign q_pop = go;
    assign out_ch.valid = ov_reg;
    assign out_ch.verdict = vd_reg;
    assign c = q_data.data;

    // innermost entry
    assign top_idx = IDX_BITS'(lvl_reg - LVL_BITS'(1));
    assign top_arr = arr_flag_reg[top_idx];
    assign top_cnt = cnt_reg[top_idx];
    assign lim = top_arr ? capv(max_items) : capv(max_fields);
    assign bump_ok = (lvl_reg != '0) && (top_cnt < lim);
    assign lw = 2'(st_reg - S_LIT_T);
    assign llen = (lw == 2'd1) ? 3'd5 : 3'd4;

    always_comb
    begin
        st_next = st_reg;
        lvl_next = lvl_reg;
        rec_next = rec_reg;
        tp_next = tp_reg;
        err_next = err_reg;
        bump_en = 1'b0;
        push_en = 1'b0;
        push_arr = 1'b0;
        pop_en = 1'b0;
        s = st_reg;
        num_done = 1'b0;

        if (!err_reg)
        begin
            // number states: consume or fall through to AFTER
            if (st_reg >= S_NUM_SIGN && st_reg <= S_NUM_EDIG)
            begin
                num_done = 1'b1;
                unique case (st_reg)
                    S_NUM_SIGN:
                    begin
                        if (c == "0") st_next = S_NUM_ZERO;
                        else if (q_data.digit) st_next = S_NUM_INT;
                        else err_next = 1'b1;
                    end
                    S_NUM_ZERO, S_NUM_INT:
                    begin
                        if (q_data.digit && st_reg == S_NUM_INT) st_next = st_reg;
                        else if (c == ".") st_next = S_NUM_DOT;
                        else if (q_data.expo) st_next = S_NUM_EXP;
                        else num_done = 1'b0;
                    end
                    S_NUM_DOT:
                    begin
                        if (q_data.digit) st_next = S_NUM_FRAC;
                        else err_next = 1'b1;
                    end
                    S_NUM_FRAC:
                    begin
                        if (q_data.digit) st_next = st_reg;
                        else if (q_data.expo) st_next = S_NUM_EXP;
                        else num_done = 1'b0;
                    end
                    S_NUM_EXP:
                    begin
                        if (c == "+" || c == "-") st_next = S_NUM_ESIGN;
                        else if (q_data.digit) st_next = S_NUM_EDIG;
                        else err_next = 1'b1;
                    end
                    S_NUM_ESIGN:
                    begin
                        if (q_data.digit) st_next = S_NUM_EDIG;
                        else err_next = 1'b1;
                    end
                    default:
                    begin
                        num_done = q_data.digit;
                    end
                endcase
                if (!num_done)
                begin
                    s = S_AFTER;
                    st_next = S_AFTER;
                end
            end

            if (!num_done && !(s <= S_AFTER && q_data.ws))
            begin
                unique case (s)
                    S_TOP:
                    begin
                        if (top_form)
                        begin
                            if (c == "[") st_next = S_REC_FIRST;
                            else err_next = 1'b1;
                        end
                        else if (c == "{")
                        begin
                            push_en = 1'b1;
                            st_next = S_OBJ_FIRST;
                        end
                        else err_next = 1'b1;
                    end
                    S_REC_FIRST, S_REC_NEXT:
                    begin
                        if (c == "]" && s == S_REC_FIRST) st_next = S_END;
                        else if (c == "{")
                        begin
                            if (rec_reg >= capv(max_records)) err_next = 1'b1;
                            else
                            begin
                                rec_next = rec_reg + COUNT_BITS'(1);
                                push_en = 1'b1;
                                st_next = S_OBJ_FIRST;
                            end
                        end
                        else err_next = 1'b1;
                    end
                    S_REC_AFTER:
                    begin
                        if (c == "]") st_next = S_END;
                        else if (c == ",") st_next = S_REC_NEXT;
                        else err_next = 1'b1;
                    end
                    S_OBJ_FIRST, S_OBJ_KEY:
                    begin
                        if (c == "}" && s == S_OBJ_FIRST) pop_en = 1'b1;
                        else if (c == "\"" && bump_ok)
                        begin
                            bump_en = 1'b1;
                            tp_next = 4'd8;
                            st_next = S_STR;
                        end
                        else err_next = 1'b1;
                    end
                    S_COLON:
                    begin
                        if (c == ":") st_next = S_VALUE;
                        else err_next = 1'b1;
                    end
                    S_VALUE, S_ARR_FIRST:
                    begin
                        if (s == S_ARR_FIRST && c == "]") pop_en = 1'b1;
                        else if (s == S_ARR_FIRST && !bump_ok) err_next = 1'b1;
                        else
                        begin
                            if (s == S_ARR_FIRST) bump_en = 1'b1;
                            if (lvl_reg > LVL_BITS'(MAX_DEPTH)) err_next = 1'b1;
                            else
                            begin
                                tp_next = 4'd1;
                                // a bump of the parent in the same byte never
                                // collides: the push lands one entry higher
                                if (c == "{" || c == "[")
                                begin
                                    push_en = 1'b1;
                                    push_arr = c == "[";
                                    st_next = (c == "{") ? S_OBJ_FIRST : S_ARR_FIRST;
                                end
                                else if (c == "\"") begin tp_next = 4'd0; st_next = S_STR; end
                                else if (c == "-") st_next = S_NUM_SIGN;
                                else if (c == "0") st_next = S_NUM_ZERO;
                                else if (q_data.digit) st_next = S_NUM_INT;
                                else if (c == "t") st_next = S_LIT_T;
                                else if (c == "f") st_next = S_LIT_F;
                                else if (c == "n") st_next = S_LIT_N;
                                else err_next = 1'b1;
                            end
                        end
                    end
                    S_AFTER:
                    begin
                        if (lvl_reg != '0 && c == (top_arr ? "]" : "}")) pop_en = 1'b1;
                        else if (c != ",") err_next = 1'b1;
                        else if (!(lvl_reg != '0 && top_arr)) st_next = S_OBJ_KEY;
                        else if (bump_ok)
                        begin
                            bump_en = 1'b1;
                            st_next = S_VALUE;
                        end
                        else err_next = 1'b1;
                    end
                    S_STR:
                    begin
                        if (c == "\"") st_next = tp_reg[3] ? S_COLON : S_AFTER;
                        else if (q_data.ctrl) err_next = 1'b1;
                        else if (c == "\\") st_next = S_STR_ESC;
                    end
                    S_STR_ESC:
                    begin
                        if (q_data.esc) st_next = S_STR;
                        else if (c == "u")
                        begin
                            tp_next = {tp_reg[3], 3'd0};
                            st_next = S_STR_HEX;
                        end
                        else err_next = 1'b1;
                    end
                    S_STR_HEX:
                    begin
                        if (q_data.hex)
                        begin
                            tp_next = tp_reg + 4'd1;
                            if (tp_next[2:0] >= 3'd4)
                            begin
                                tp_next = {tp_reg[3], 3'd0};
                                st_next = S_STR;
                            end
                        end
                        else err_next = 1'b1;
                    end
                    S_LIT_T, S_LIT_F, S_LIT_N:
                    begin
                        if (tp_reg[2:0] >= llen || c != lit_char(lw, tp_reg[2:0]))
                            err_next = 1'b1;
                        else
                        begin
                            tp_next = tp_reg + 4'd1;
                            if (tp_next[2:0] >= llen) st_next = S_AFTER;
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase

                // close the innermost container
                if (pop_en)
                begin
                    lvl_next = lvl_reg - LVL_BITS'(1);
                    if (lvl_next != '0) st_next = S_AFTER;
                    else st_next = top_form ? S_REC_AFTER : S_END;
                end
                if (push_en)
                    lvl_next = lvl_reg + LVL_BITS'(1);
            end
        end

        // state the byte leaves behind, before the end-of-document clear
        st_fin = st_next;
        err_fin = err_next;

        if (q_data.last)
        begin
            st_next = S_TOP;
            lvl_next = '0;
            rec_next = '0;
            tp_next = 4'd0;
            err_next = 1'b0;
        end
    end

    always_comb
    begin
        ov_next = ov_reg && !out_ch.ready;
        vd_next = vd_reg;
        if (go && q_data.last)
        begin
            ov_next = 1'b1;
            vd_next = err_fin || (st_fin != S_END);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_TOP;
            lvl_reg <= '0;
            rec_reg <= '0;
            tp_reg <= 4'd0;
            err_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
            if (go)
            begin
                st_reg <= st_next;
                lvl_reg <= lvl_next;
                rec_reg <= rec_next;
                tp_reg <= tp_next;
                err_reg <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vd_reg <= vd_next;
        if (go && bump_en && !q_data.last)
            cnt_reg[top_idx] <= top_cnt + COUNT_BITS'(1);
        if (go && push_en && !q_data.last)
        begin
            arr_flag_reg[IDX_BITS'(lvl_reg)] <= push_arr;
            cnt_reg[IDX_BITS'(lvl_reg)] <= '0;
        end
    end
endmodule

[rtl/json_syntax_checker.sv]
// JSON syntax checker: bytes enter on in_ch, one per cycle at full rate, and
// one verdict (0 = well formed within the limits, 1 = rejected) leaves on
// out_ch for each byte marked last. Each byte is a single update of the
// parse state and the container stack in the back end; a two-entry queue
// parts the classifying front end from it, and a verdict register lets the
// stream go on while a verdict waits; a verdict is offered from it once
// the back end pops its last byte. Only a last byte that finds the
// previous verdict still waiting holds in the queue; the input stalls once
// the queue is full behind it. Write configuration only while idle.
module json_syntax_checker #(
    parameter int MAX_DEPTH = 16,
    parameter int COUNT_BITS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    jsc_in_if.sink                       in_ch,
    jsc_out_if.source                    out_ch,
    input  logic                         cfg_we,
    input  logic [jsc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [jsc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import jsc_pkg::*;

    logic       top_form_reg;
    logic [9:0] max_fields_reg, max_items_reg, max_records_reg;
    logic       push, full, pop, not_empty;
    cls_byte_t  push_data, pop_data;

    // hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_form_reg <= 1'b0;
            max_fields_reg <= 10'd128;
            max_items_reg <= 10'd512;
            max_records_reg <= 10'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOP_FORM:    top_form_reg <= cfg_data[0];
                REG_MAX_FIELDS:  max_fields_reg <= cfg_data;
                REG_MAX_ITEMS:   max_items_reg <= cfg_data;
                REG_MAX_RECORDS: max_records_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    jsc_front u_front (.in_ch(in_ch), .push(push), .push_data(push_data), .q_full(full));

    jsc_fifo u_fifo (.clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
                     .full(full), .pop(pop), .pop_data(pop_data), .not_empty(not_empty));

    jsc_back #(.MAX_DEPTH(MAX_DEPTH), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(not_empty), .q_data(pop_data), .q_pop(pop),
        .top_form(top_form_reg), .max_fields(max_fields_reg), .max_items(max_items_reg),
        .max_records(max_records_reg), .out_ch(out_ch));
endmodule
